[sv/stu_pkg.sv]
// Package for the stride scheduler table unit.
// Holds request, status and slot-state codes, default sizes and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package stu_pkg;

  localparam int NUM_SLOTS_DEF  = 16;
  localparam int STRIDE_NUM_DEF = 65536;

  localparam int PASS_W = 64;
  localparam int ID_W   = 31;
  localparam int PRIO_W = 8;

  localparam logic [PRIO_W-1:0] PRIO_RESET = 8'd16;
  localparam logic [ID_W-1:0]   ID_RESET   = 31'd1;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_SET   = 2'd1;
  localparam logic [1:0] REQ_SCHED = 2'd2;

  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_NO_FREE     = 2'd1;
  localparam logic [1:0] STAT_NO_RUNNABLE = 2'd2;

  localparam logic [2:0] ST_UNUSED   = 3'd0;
  localparam logic [2:0] ST_USED     = 3'd1;
  localparam logic [2:0] ST_RUNNABLE = 3'd2;
  localparam logic [2:0] ST_RUNNING  = 3'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET,
    S_SCAN,
    S_FIN,
    S_ALLOC_W
  } stu_fsm_t;

endpackage

[sv/stu_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Uses no package items.
`timescale 1ns / 1ps

module stu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/stu_div.sv]
// Bit-serial restoring divider: a fixed numerator divided by an 8-bit priority.
// One quotient bit per cycle. Depends on stu_pkg.
`timescale 1ns / 1ps

module stu_div import stu_pkg::*; #(
  parameter int NUMERATOR = STRIDE_NUM_DEF,
  parameter int NUM_W     = $clog2(NUMERATOR + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PRIO_W-1:0] divisor,
  output logic [NUM_W-1:0]  quotient,
  output logic              done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [PRIO_W-1:0] div_r;
  logic [PRIO_W-1:0] rem_r;
  logic [NUM_W-1:0]  num_r;
  logic [NUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [PRIO_W:0] trial;
  logic            fits;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      rem_r <= '0;
      num_r <= NUM_W'(NUMERATOR);
      quo_r <= '0;
    end else if (busy_r) begin
      // The remainder stays below the divisor, so it fits back into PRIO_W bits.
      rem_r <= fits ? PRIO_W'(trial - {1'b0, div_r}) : trial[PRIO_W-1:0];
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

[sv/stride_scheduler_table_unit.sv]
// Stride scheduler table unit: top level with the request sequencer. Uses stu_pkg, stu_ram, stu_div.
// Set-state and unknown requests answer from S_SET; schedule scans every slot, one slot
// read per cycle, and answers from S_FIN; allocate scans up to the first free slot and answers
// from S_ALLOC_W once the divider (one quotient bit per cycle) is done, or from S_FIN if none is free.
// One request at a time; the next one can be accepted at the edge that takes the result beat.
// Reset (rst_n, synchronous) frees every slot, sets id 1 and priority 16; no receiver stall.
`timescale 1ns / 1ps

module stride_scheduler_table_unit import stu_pkg::*; #(
  parameter int NUM_SLOTS        = NUM_SLOTS_DEF,
  parameter int STRIDE_NUMERATOR = STRIDE_NUM_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_req_type,
  input  logic [3:0]        in_slot,
  input  logic [2:0]        in_new_state,
  input  logic [PRIO_W-1:0] in_priority_req,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [3:0]        out_chosen_slot,
  output logic [ID_W-1:0]   out_task_id,
  input  logic              cfg_we,
  input  logic [PRIO_W-1:0] cfg_wdata
);

  localparam int IDX_W    = $clog2(NUM_SLOTS);
  localparam int CNT_W    = IDX_W + 1;
  localparam int STRIDE_W = $clog2(STRIDE_NUMERATOR + 1);
  localparam int DATA_W   = PASS_W + STRIDE_W + ID_W;

  stu_fsm_t state_r, state_nxt;

  logic [PRIO_W-1:0] def_prio_r;
  logic [ID_W-1:0]   next_id_r;
  logic              valid_r [NUM_SLOTS];

  logic [1:0]        req_type_r;
  logic [3:0]        req_slot_r;
  logic [2:0]        req_nstate_r;

  logic [CNT_W-1:0]    rd_cnt_r;
  logic                cmp_vld_r;
  logic [IDX_W-1:0]    cmp_idx_r;
  logic                vld_q_r;
  logic                found_r;
  logic [IDX_W-1:0]    best_idx_r;
  logic [PASS_W-1:0]   best_pass_r;
  logic [STRIDE_W-1:0] best_stride_r;
  logic [ID_W-1:0]     best_id_r;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [3:0]        out_slot_r;
  logic [ID_W-1:0]   out_id_r;

  logic                accept;
  logic                rd_issue;
  logic [IDX_W-1:0]    raddr;
  logic [2:0]          st_q;
  logic [DATA_W-1:0]   dat_q;
  logic [2:0]          eff_st;
  logic [PASS_W-1:0]   q_pass;
  logic [STRIDE_W-1:0] q_stride;
  logic [ID_W-1:0]     q_id;
  logic                is_alloc;
  logic                cmp_hit;
  logic                scan_end;

  logic [IDX_W+3:0]  slot_ext;
  logic [IDX_W+3:0]  best_ext;
  logic              slot_ok;
  logic [PRIO_W-1:0] prio_eff;
  logic              div_start;
  logic [STRIDE_W-1:0] div_quo;
  logic              div_done;

  logic              st_we;
  logic [IDX_W-1:0]  st_waddr;
  logic [2:0]        st_wdata;
  logic              dat_we;
  logic [DATA_W-1:0] dat_wdata;
  logic              res_fire;
  logic [1:0]        res_status;
  logic [3:0]        res_slot;
  logic [ID_W-1:0]   res_id;

  assign busy   = state_r != S_IDLE;
  assign accept = start && !busy;

  // Tables. Writes happen only outside a scan (in S_SET, S_FIN and S_ALLOC_W), so a later scan
  // always sees them and no forwarding is needed.
  stu_ram #(.WIDTH(3), .DEPTH(NUM_SLOTS)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (raddr),
    .rdata (st_q)
  );

  stu_ram #(.WIDTH(DATA_W), .DEPTH(NUM_SLOTS)) u_data_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (st_waddr),
    .wdata (dat_wdata),
    .raddr (raddr),
    .rdata (dat_q)
  );

  assign prio_eff  = (in_priority_req != '0) ? in_priority_req :
                     (def_prio_r != '0) ? def_prio_r : PRIO_W'(1);
  assign div_start = accept && (in_req_type == REQ_ALLOC);

  stu_div #(.NUMERATOR(STRIDE_NUMERATOR), .NUM_W(STRIDE_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (prio_eff),
    .quotient (div_quo),
    .done     (div_done)
  );

  assign raddr    = rd_cnt_r[IDX_W-1:0];
  assign rd_issue = (state_r == S_SCAN) && (rd_cnt_r < CNT_W'(NUM_SLOTS));

  // A slot whose valid bit is clear has never been written since reset and reads as unused.
  assign eff_st   = vld_q_r ? st_q : ST_UNUSED;
  assign q_pass   = dat_q[DATA_W-1 -: PASS_W];
  assign q_stride = dat_q[ID_W +: STRIDE_W];
  assign q_id     = dat_q[ID_W-1:0];
  assign is_alloc = req_type_r == REQ_ALLOC;

  assign cmp_hit  = cmp_vld_r && (is_alloc ? (eff_st == ST_UNUSED) :
                    ((eff_st == ST_RUNNABLE) && (!found_r || (q_pass < best_pass_r))));
  assign scan_end = cmp_vld_r && ((is_alloc && (eff_st == ST_UNUSED)) ||
                    (cmp_idx_r == IDX_W'(NUM_SLOTS - 1)));

  assign slot_ext = {{IDX_W{1'b0}}, req_slot_r};
  assign slot_ok  = slot_ext < (IDX_W + 4)'(NUM_SLOTS);
  assign best_ext = {4'b0000, best_idx_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req_type inside {REQ_ALLOC, REQ_SCHED}) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_SET;
          end
        end
      end
      S_SET: begin
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = (is_alloc && found_r) ? S_ALLOC_W : S_IDLE;
      end
      S_ALLOC_W: begin
        if (div_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_fire   = 1'b0;
    res_status = STAT_OK;
    res_slot   = '0;
    res_id     = '0;
    st_we      = 1'b0;
    st_waddr   = best_idx_r;
    st_wdata   = ST_USED;
    dat_we     = 1'b0;
    dat_wdata  = {PASS_W'(0), div_quo, next_id_r};
    case (state_r)
      S_SET: begin
        res_fire = 1'b1;
        if (req_type_r == REQ_SET) begin
          res_slot = req_slot_r;
          if (slot_ok) begin
            st_we    = 1'b1;
            st_waddr = slot_ext[IDX_W-1:0];
            st_wdata = req_nstate_r;
          end
        end
      end
      S_FIN: begin
        if (!found_r) begin
          res_fire   = 1'b1;
          res_status = is_alloc ? STAT_NO_FREE : STAT_NO_RUNNABLE;
        end else if (!is_alloc) begin
          // The stride is charged at selection time; a running slot is never compared.
          res_fire  = 1'b1;
          res_slot  = best_ext[3:0];
          res_id    = best_id_r;
          st_we     = 1'b1;
          st_wdata  = ST_RUNNING;
          dat_we    = 1'b1;
          dat_wdata = {best_pass_r + {{(PASS_W - STRIDE_W){1'b0}}, best_stride_r},
                       best_stride_r, best_id_r};
        end
      end
      S_ALLOC_W: begin
        if (div_done) begin
          res_fire = 1'b1;
          res_slot = best_ext[3:0];
          res_id   = next_id_r;
          st_we    = 1'b1;
          st_wdata = ST_USED;
          dat_we   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      def_prio_r  <= PRIO_RESET;
      next_id_r   <= ID_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= res_fire;
      if (cfg_we) begin
        def_prio_r <= cfg_wdata;
      end
      if (st_we) begin
        valid_r[st_waddr] <= 1'b1;
      end
      if ((state_r == S_ALLOC_W) && div_done) begin
        next_id_r <= next_id_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r  <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else if (accept) begin
      rd_cnt_r  <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else if (state_r == S_SCAN) begin
      rd_cnt_r  <= rd_cnt_r + CNT_W'(rd_issue);
      cmp_vld_r <= rd_issue;
      if (cmp_hit) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_r   <= in_req_type;
      req_slot_r   <= in_slot;
      req_nstate_r <= in_new_state;
    end
    if (state_r == S_SCAN) begin
      cmp_idx_r <= raddr;
      vld_q_r   <= valid_r[raddr];
      if (cmp_hit) begin
        best_idx_r    <= cmp_idx_r;
        best_pass_r   <= q_pass;
        best_stride_r <= q_stride;
        best_id_r     <= q_id;
      end
    end
    if (res_fire) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_id_r     <= res_id;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_chosen_slot = out_slot_r;
  assign out_task_id     = out_id_r;

endmodule

[dv/stride_scheduler_table_unit_tb.sv]
// Self-checking testbench for stride_scheduler_table_unit: directed and random request beats
// checked against an in-bench image of the slot table. Depends on stu_pkg and the RTL.
`timescale 1ns / 1ps

module stride_scheduler_table_unit_tb;
  import stu_pkg::*;

  localparam int SLOTS       = NUM_SLOTS_DEF;
  localparam int STRIDE_NUM  = STRIDE_NUM_DEF;
  localparam int PHASE_ITEMS = 96;
  localparam int MAX_SHOWN   = 10;
  localparam int TIMEOUT_NS  = 3_000_000;
  localparam int DRAIN_TAIL  = 40;

  localparam logic [1:0] REQ_UNKNOWN   = 2'd3;
  localparam logic [2:0] ST_ZOMBIE     = 3'd4;
  localparam logic [2:0] ST_UNNAMED_LO = 3'd5;

  typedef struct packed {
    logic [1:0]        kind;
    logic [3:0]        slot;
    logic [2:0]        nstate;
    logic [PRIO_W-1:0] prio;
    logic [4:0]        gap;
  } sched_req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [3:0]      slot;
    logic [ID_W-1:0] id;
  } sched_resp_t;

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              start           = 1'b0;
  logic              busy;
  logic [1:0]        in_req_type     = '0;
  logic [3:0]        in_slot         = '0;
  logic [2:0]        in_new_state    = '0;
  logic [PRIO_W-1:0] in_priority_req = '0;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [3:0]        out_chosen_slot;
  logic [ID_W-1:0]   out_task_id;
  logic              cfg_we          = 1'b0;
  logic [PRIO_W-1:0] cfg_wdata       = '0;

  // Image of the slot table kept by the predictor.
  logic [2:0]        tbl_state  [SLOTS];
  logic [PASS_W-1:0] tbl_pass   [SLOTS];
  logic [31:0]       tbl_stride [SLOTS];
  logic [ID_W-1:0]   tbl_id     [SLOTS];
  bit                tbl_alloc  [SLOTS];
  logic [ID_W-1:0]   id_counter;
  logic [PRIO_W-1:0] dflt_prio;

  sched_req_t  pending_reqs[$];
  sched_resp_t awaited_resps[$];
  sched_req_t  held_req;
  sched_req_t  cur_req;
  bit          held        = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned errors      = 0;
  bit          burst       = 1'b0;

  stride_scheduler_table_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_slot         (in_slot),
    .in_new_state    (in_new_state),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_chosen_slot (out_chosen_slot),
    .out_task_id     (out_task_id),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Applies one request to the table image and returns the answer it should produce.
  function automatic sched_resp_t serve_request(input sched_req_t r);
    sched_resp_t rsp;
    int          pick;
    int          i;
    int unsigned p;
    rsp  = '0;
    pick = -1;
    case (r.kind)
      REQ_ALLOC: begin
        for (i = SLOTS - 1; i >= 0; i--) begin
          if (tbl_state[i] == ST_UNUSED) pick = i;
        end
        if (pick < 0) begin
          rsp.status = STAT_NO_FREE;
        end else begin
          p = 32'((r.prio != 0) ? r.prio : dflt_prio);
          if (p == 0) p = 1;
          tbl_id[pick]     = id_counter;
          id_counter       = id_counter + 1'b1;
          tbl_state[pick]  = ST_USED;
          tbl_pass[pick]   = '0;
          tbl_stride[pick] = STRIDE_NUM / p;
          tbl_alloc[pick]  = 1'b1;
          rsp.slot         = pick[3:0];
          rsp.id           = tbl_id[pick];
        end
      end
      REQ_SET: begin
        if (r.slot < SLOTS) tbl_state[r.slot] = r.nstate;
        rsp.slot = r.slot;
      end
      REQ_SCHED: begin
        for (i = 0; i < SLOTS; i++) begin
          if (tbl_state[i] == ST_RUNNABLE && (pick < 0 || tbl_pass[i] < tbl_pass[pick]))
            pick = i;
        end
        if (pick < 0) begin
          rsp.status = STAT_NO_RUNNABLE;
        end else begin
          tbl_state[pick] = ST_RUNNING;
          tbl_pass[pick]  = tbl_pass[pick] + PASS_W'(tbl_stride[pick]);
          rsp.slot        = pick[3:0];
          rsp.id          = tbl_id[pick];
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // Driver: presents one request at a time after its own idle gap.
  always @(posedge clk) begin : driver
    int i;
    if (!rst_n) begin
      start       <= 1'b0;
      held        = 1'b0;
      hold_cycles = 0;
      for (i = 0; i < SLOTS; i++) begin
        tbl_state[i] = ST_UNUSED;
        tbl_alloc[i] = 1'b0;
      end
      id_counter = ID_RESET;
      dflt_prio  = PRIO_RESET;
    end else begin
      if (start && !busy) awaited_resps.push_back(serve_request(cur_req));
      if (!(start && busy)) begin
        if (!held && pending_reqs.size() != 0) begin
          held_req    = pending_reqs.pop_front();
          held        = 1'b1;
          hold_cycles = 32'(held_req.gap);
        end
        if (held && hold_cycles == 0) begin
          // A slot that never went through allocate must not become runnable.
          if (held_req.kind == REQ_SET && held_req.nstate == ST_RUNNABLE &&
              !tbl_alloc[held_req.slot])
            held_req.nstate = ST_USED;
          cur_req         = held_req;
          held            = 1'b0;
          start           <= 1'b1;
          in_req_type     <= held_req.kind;
          in_slot         <= held_req.slot;
          in_new_state    <= held_req.nstate;
          in_priority_req <= held_req.prio;
        end else begin
          if (held) hold_cycles--;
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result beat is matched against the oldest expected answer.
  always @(posedge clk) begin : monitor
    sched_resp_t want;
    if (rst_n && out_valid) begin
      if (awaited_resps.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: result beat with nothing expected: status %0d slot %0d id %0d",
                   $time, out_status, out_chosen_slot, out_task_id);
      end else begin
        want = awaited_resps.pop_front();
        if (out_status !== want.status || out_chosen_slot !== want.slot ||
            out_task_id !== want.id) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("%0t: expected status %0d slot %0d id %0d, got status %0d slot %0d id %0d",
                     $time, want.status, want.slot, want.id,
                     out_status, out_chosen_slot, out_task_id);
        end
      end
    end
  end

  task automatic queue_req(input logic [1:0] kind, input logic [3:0] slot,
                           input logic [2:0] st, input logic [PRIO_W-1:0] prio);
    sched_req_t r;
    r.kind   = kind;
    r.slot   = slot;
    r.nstate = st;
    r.prio   = prio;
    r.gap    = 5'($urandom_range(0, 17));
    pending_reqs.push_back(r);
  endtask

  // Mostly allocate, make runnable, schedule and release, with some noise.
  task automatic add_random(input int n);
    sched_req_t  r;
    int unsigned roll;
    int          k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0) burst = !burst;
      r.slot   = 4'($urandom_range(0, 15));
      r.nstate = 3'($urandom_range(0, 7));
      r.prio   = PRIO_W'($urandom_range(0, 255));
      roll     = $urandom_range(0, 99);
      if (roll < 22) r.kind = REQ_ALLOC;
      else if (roll < 57) r.kind = REQ_SET;
      else if (roll < 95) r.kind = REQ_SCHED;
      else r.kind = REQ_UNKNOWN;
      roll = $urandom_range(0, 99);
      if (r.kind == REQ_SET) begin
        if (roll < 45) r.nstate = ST_RUNNABLE;
        else if (roll < 70) r.nstate = ST_UNUSED;
      end else if (r.kind == REQ_ALLOC) begin
        if (roll < 30) r.prio = '0;
        else if (roll < 38) r.prio = 8'd1;
        else if (roll < 45) r.prio = '1;
      end
      r.gap = burst ? 5'd0 : 5'($urandom_range(0, 17));
      pending_reqs.push_back(r);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || held || start || busy || awaited_resps.size() != 0);
  endtask

  task automatic write_default_prio(input logic [PRIO_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    dflt_prio = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [PRIO_W-1:0] prio_vals [5];
    int                ph;
    int                s;
    prio_vals[0] = '1;
    prio_vals[1] = '0;
    prio_vals[2] = 8'd1;
    prio_vals[3] = PRIO_W'($urandom_range(2, 254));
    prio_vals[4] = PRIO_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty table, then three allocations that tie at pass zero.
    queue_req(REQ_SCHED, 4'd0, ST_UNUSED, 8'd0);
    queue_req(REQ_ALLOC, 4'd0, ST_UNUSED, 8'd0);
    queue_req(REQ_ALLOC, 4'd0, ST_UNUSED, 8'd255);
    queue_req(REQ_ALLOC, 4'd0, ST_UNUSED, 8'd1);
    for (s = 0; s < 3; s++) queue_req(REQ_SET, 4'(s), ST_RUNNABLE, 8'd0);
    repeat (4) queue_req(REQ_SCHED, 4'd0, ST_UNUSED, 8'd0);
    queue_req(REQ_UNKNOWN, 4'hF, 3'h7, 8'hFF);
    // Occupy the rest of the table with named and unnamed states, then allocate into it.
    for (s = 3; s < SLOTS; s++) begin
      case (s)
        3:       queue_req(REQ_SET, 4'(s), ST_RUNNING, 8'd0);
        12:      queue_req(REQ_SET, 4'(s), ST_UNNAMED_LO + 3'd1, 8'd0);
        13:      queue_req(REQ_SET, 4'(s), ST_UNNAMED_LO, 8'd0);
        14:      queue_req(REQ_SET, 4'(s), ST_ZOMBIE, 8'd0);
        15:      queue_req(REQ_SET, 4'(s), ST_UNNAMED_LO + 3'd2, 8'd0);
        default: queue_req(REQ_SET, 4'(s), ST_USED, 8'd0);
      endcase
    end
    queue_req(REQ_ALLOC, 4'd0, ST_UNUSED, 8'd0);

    add_random(PHASE_ITEMS);
    wait_idle();
    for (ph = 0; ph < 5; ph++) begin
      write_default_prio(prio_vals[ph]);
      @(negedge clk);
      add_random(PHASE_ITEMS);
      wait_idle();
    end

    repeat (DRAIN_TAIL) @(posedge clk);
    if (errors == 0 && awaited_resps.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
